[sv/gfbp_pkg.sv]
// Shared constants, types and the gray-to-plane lookup for the gray FRC bit-plane packer.
// Has no dependencies. Every other file of the block uses it.
package gfbp_pkg;

	localparam int PAGE_COUNT  = 5;
	localparam int PAGE_W      = 3;
	localparam int GRAY_W      = 4;
	localparam int OVL_W       = 3;
	localparam int ROW_PIXELS  = 8;
	localparam int LANE_COUNT  = 2 * ROW_PIXELS;
	localparam int IN_DATA_W   = 2 * ROW_PIXELS * GRAY_W + 2 * ROW_PIXELS * OVL_W;
	localparam int OUT_DATA_W  = 32;

	localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);
	localparam logic [PAGE_W-1:0] PAGE_FIRST = '0;

	typedef logic [1:0] planes_t;
	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [GRAY_W-1:0] gray_t;
	typedef logic [OVL_W-1:0] ovl_t;

	// Each entry holds {plane1, plane0} for one gray level on one frame page.
	localparam planes_t FRC_TABLE [PAGE_COUNT][16] = '{
		'{2'b00, 2'b10, 2'b00, 2'b10, 2'b10, 2'b10, 2'b01, 2'b10,
		  2'b01, 2'b01, 2'b01, 2'b11, 2'b01, 2'b11, 2'b11, 2'b11},
		'{2'b00, 2'b00, 2'b10, 2'b00, 2'b10, 2'b10, 2'b10, 2'b01,
		  2'b10, 2'b01, 2'b01, 2'b01, 2'b11, 2'b01, 2'b11, 2'b11},
		'{2'b00, 2'b00, 2'b00, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10,
		  2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b11, 2'b11, 2'b11},
		'{2'b00, 2'b00, 2'b10, 2'b00, 2'b10, 2'b10, 2'b10, 2'b01,
		  2'b10, 2'b01, 2'b01, 2'b01, 2'b11, 2'b01, 2'b11, 2'b11},
		'{2'b00, 2'b00, 2'b00, 2'b10, 2'b00, 2'b10, 2'b10, 2'b10,
		  2'b01, 2'b10, 2'b01, 2'b01, 2'b01, 2'b11, 2'b01, 2'b11}
	};

endpackage

[sv/gfbp_lane.sv]
// One pixel lane: overlay merge followed by the frame-page table lookup.
// Depends on gfbp_pkg for widths, types and the lookup table.
module gfbp_lane (
	input  gfbp_pkg::gray_t   gray,
	input  gfbp_pkg::ovl_t    overlay,
	input  logic              overlay_enable,
	input  gfbp_pkg::page_t   page,
	output gfbp_pkg::planes_t planes
);

	gfbp_pkg::gray_t level;

	always_comb begin
		level = gray;
		if (overlay_enable && !overlay[2]) begin
			level = {overlay[1:0], overlay[1:0]};
		end
	end

	assign planes = gfbp_pkg::FRC_TABLE[page][level];

endmodule

[sv/gfbp_merge.sv]
// Merging stage: packs the sixteen lane results into one LCD word and holds it in the output register.
// Depends on gfbp_pkg for widths and types.
module gfbp_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  gfbp_pkg::planes_t                 lane_planes [gfbp_pkg::LANE_COUNT],
	input  gfbp_pkg::page_t                   page,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gfbp_pkg::OUT_DATA_W-1:0]   out_word,
	output gfbp_pkg::page_t                   out_page
);

	localparam int RP = gfbp_pkg::ROW_PIXELS;

	logic [gfbp_pkg::OUT_DATA_W-1:0] word;
	logic                            valid_q;
	logic [gfbp_pkg::OUT_DATA_W-1:0] word_q;
	gfbp_pkg::page_t                 page_q;
	logic                            load;

	always_comb begin
		for (int i = 0; i < RP; i++) begin
			word[i]          = lane_planes[i][0];
			word[RP + i]     = lane_planes[i][1];
			word[2 * RP + i] = lane_planes[RP + i][0];
			word[3 * RP + i] = lane_planes[RP + i][1];
		end
	end

	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word;
			page_q <= page;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;
	assign out_page  = page_q;

endmodule

[sv/gray_frc_bitplane_packer.sv]
// Top level of the gray FRC bit-plane packer: sixteen pixel lanes, the merging stage and the page counter.
// Depends on gfbp_pkg, gfbp_lane and gfbp_merge.
//
// Channel   Direction  Signals                        Contents
// s_axis    in         tvalid tready tdata tlast      two rows of 8 pixels with overlays, frame end
// m_axis    out        tvalid tready tdata tuser      packed LCD word, frame page used
// cfg       in         cfg_wr_en cfg_wr_data          overlay enable register
//
// Every transaction passes through the combinational lanes and is captured in the output register when accepted.
// A new transaction is accepted each cycle while the output register is empty or being drained.
// A stall on m_axis holds the output word and blocks s_axis only while the register is full.
// Reset clears the frame page to zero, the overlay enable and the output valid flag.
module gray_frc_bitplane_packer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0: upper_row_pixels, lower_row_pixels, upper_row_overlay, lower_row_overlay.
	input  logic [gfbp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// Fields from bit 0: lcd_word.
	output logic [gfbp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// Fields from bit 0: page_used.
	output logic [gfbp_pkg::PAGE_W-1:0]         m_axis_tuser,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_wr_data
);

	localparam int RP  = gfbp_pkg::ROW_PIXELS;
	localparam int GW  = gfbp_pkg::GRAY_W;
	localparam int OW  = gfbp_pkg::OVL_W;
	localparam int LO_PIX_LSB = RP * GW;
	localparam int UP_OVL_LSB = 2 * RP * GW;
	localparam int LO_OVL_LSB = 2 * RP * GW + RP * OW;

	logic              overlay_enable_q;
	gfbp_pkg::page_t   page_q;
	gfbp_pkg::planes_t lane_planes [gfbp_pkg::LANE_COUNT];
	logic              s_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlay_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			overlay_enable_q <= cfg_wr_data;
		end
	end

	assign s_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= gfbp_pkg::PAGE_FIRST;
		end else if (s_accept && s_axis_tlast) begin
			if (page_q == gfbp_pkg::PAGE_LAST) begin
				page_q <= gfbp_pkg::PAGE_FIRST;
			end else begin
				page_q <= page_q + 1'b1;
			end
		end
	end

	for (genvar i = 0; i < RP; i++) begin : g_lanes
		gfbp_lane u_upper (
			.gray           (s_axis_tdata[i * GW +: GW]),
			.overlay        (s_axis_tdata[UP_OVL_LSB + i * OW +: OW]),
			.overlay_enable (overlay_enable_q),
			.page           (page_q),
			.planes         (lane_planes[i])
		);
		gfbp_lane u_lower (
			.gray           (s_axis_tdata[LO_PIX_LSB + i * GW +: GW]),
			.overlay        (s_axis_tdata[LO_OVL_LSB + i * OW +: OW]),
			.overlay_enable (overlay_enable_q),
			.page           (page_q),
			.planes         (lane_planes[RP + i])
		);
	end

	gfbp_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.lane_planes (lane_planes),
		.page        (page_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_word    (m_axis_tdata),
		.out_page    (m_axis_tuser)
	);

	a_page_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		page_q <= gfbp_pkg::PAGE_LAST)
		else $error("frame page left its range");

	a_page_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_axis_tlast && page_q == gfbp_pkg::PAGE_LAST)
		|=> page_q == gfbp_pkg::PAGE_FIRST)
		else $error("frame page did not wrap after the last page");

	a_page_reported: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (m_axis_tvalid && m_axis_tuser == $past(page_q)))
		else $error("reported page differs from the page used at acceptance");

endmodule

[bench/gfbp_lcd_checker.sv]
`timescale 1ns / 100ps
// Checker for the gray FRC bit-plane packer: watches the pixel, LCD word and register ports,
// predicts each LCD word with its own frame page and overlay enable, and counts mismatches.
// Depends on gfbp_pkg for the channel widths and the page type.
module gfbp_lcd_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [gfbp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tlast,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [gfbp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [gfbp_pkg::PAGE_W-1:0]     m_axis_tuser,
	input  logic                            cfg_wr_en,
	input  logic                            cfg_wr_data,
	output int                              pending,
	output int                              failures
);

	typedef struct packed {
		logic [31:0]     lcd_word;
		gfbp_pkg::page_t page_used;
	} lcd_result_t;

	// Bit 0 is the plane 0 bit and bit 8 the plane 1 bit of a gray level on a page.
	localparam logic [8:0] GRAY_MAP [gfbp_pkg::PAGE_COUNT][16] = '{
		'{9'h000, 9'h100, 9'h000, 9'h100, 9'h100, 9'h100, 9'h001, 9'h100,
		  9'h001, 9'h001, 9'h001, 9'h101, 9'h001, 9'h101, 9'h101, 9'h101},
		'{9'h000, 9'h000, 9'h100, 9'h000, 9'h100, 9'h100, 9'h100, 9'h001,
		  9'h100, 9'h001, 9'h001, 9'h001, 9'h101, 9'h001, 9'h101, 9'h101},
		'{9'h000, 9'h000, 9'h000, 9'h100, 9'h100, 9'h100, 9'h100, 9'h100,
		  9'h001, 9'h001, 9'h001, 9'h001, 9'h001, 9'h101, 9'h101, 9'h101},
		'{9'h000, 9'h000, 9'h100, 9'h000, 9'h100, 9'h100, 9'h100, 9'h001,
		  9'h100, 9'h001, 9'h001, 9'h001, 9'h101, 9'h001, 9'h101, 9'h101},
		'{9'h000, 9'h000, 9'h000, 9'h100, 9'h000, 9'h100, 9'h100, 9'h100,
		  9'h001, 9'h100, 9'h001, 9'h001, 9'h001, 9'h101, 9'h001, 9'h101}
	};

	gfbp_pkg::page_t frame_page;
	logic            overlay_on;
	lcd_result_t     lcd_words_due[$];

	function automatic logic [15:0] pack_row_planes(logic [31:0] pixels, logic [23:0] overlay,
			logic merge, gfbp_pkg::page_t page);
		logic [15:0] planes;
		logic [3:0]  gray;
		logic [2:0]  ovl;
		logic [8:0]  bits;
		planes = '0;
		for (int i = 0; i < gfbp_pkg::ROW_PIXELS; i++) begin
			gray = pixels[4*i +: 4];
			ovl = overlay[3*i +: 3];
			if (merge && !ovl[2]) begin
				gray = {ovl[1:0], ovl[1:0]};
			end
			bits = GRAY_MAP[int'(page) % gfbp_pkg::PAGE_COUNT][gray];
			planes[i] = bits[0];
			planes[8+i] = bits[8];
		end
		return planes;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcd_result_t due;
		lcd_result_t got;
		if (!arst_n) begin
			frame_page = gfbp_pkg::PAGE_FIRST;
			overlay_on = 1'b0;
			lcd_words_due.delete();
			pending = 0;
			failures = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.lcd_word = m_axis_tdata;
				got.page_used = m_axis_tuser;
				if (lcd_words_due.size() == 0) begin
					$error("LCD word %h on page %0d arrived with none expected",
						got.lcd_word, got.page_used);
					failures++;
				end else begin
					due = lcd_words_due.pop_front();
					if (got.lcd_word !== due.lcd_word) begin
						$error("lcd_word expected %h, actual %h", due.lcd_word, got.lcd_word);
						failures++;
					end
					if (got.page_used !== due.page_used) begin
						$error("page_used expected %0d, actual %0d", due.page_used, got.page_used);
						failures++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				due.page_used = frame_page;
				due.lcd_word = {
					pack_row_planes(s_axis_tdata[63:32], s_axis_tdata[111:88], overlay_on,
						frame_page),
					pack_row_planes(s_axis_tdata[31:0], s_axis_tdata[87:64], overlay_on,
						frame_page)
				};
				lcd_words_due.push_back(due);
				if (s_axis_tlast) begin
					frame_page = (frame_page == gfbp_pkg::PAGE_LAST) ? gfbp_pkg::PAGE_FIRST :
						frame_page + 1'b1;
				end
			end
			if (cfg_wr_en) begin
				overlay_on = cfg_wr_data;
			end
			pending = lcd_words_due.size();
		end
	end

endmodule

[bench/tb_gray_frc_bitplane_packer.sv]
`timescale 1ns / 100ps
// Testbench top for the gray FRC bit-plane packer: clock, reset, pixel group stimulus,
// LCD word back-pressure and the verdict. Depends on gfbp_pkg, the block and gfbp_lcd_checker.
module tb_gray_frc_bitplane_packer;

	localparam int LONG_HOLD    = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_SETTLE = 4;
	localparam int RANDOM_ITEMS = 360;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [gfbp_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                            s_axis_tlast = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [gfbp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [gfbp_pkg::PAGE_W-1:0]     m_axis_tuser;
	logic                            cfg_wr_en = 1'b0;
	logic                            cfg_wr_data = 1'b0;
	int                              pending;
	int                              failures;
	int                              hold_token = 0;
	int                              idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gray_frc_bitplane_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	gfbp_lcd_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.pending      (pending),
		.failures     (failures)
	);

	task automatic offer_group(logic [31:0] upper, logic [31:0] lower, logic [23:0] upper_ovl,
			logic [23:0] lower_ovl, logic frame_end);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {lower_ovl, upper_ovl, lower, upper};
		s_axis_tlast <= frame_end;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic await_drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	task automatic write_overlay_enable(logic value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic stream_random_groups(int count, bit long_hold);
		int          burst_left;
		bit          steady;
		int          kind;
		logic [31:0] upper;
		logic [31:0] lower;
		logic [23:0] upper_ovl;
		logic [23:0] lower_ovl;
		burst_left = 0;
		steady = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				pause_sender(steady ? 0 : $urandom_range(1, 10));
				burst_left = $urandom_range(1, 32);
				steady = ($urandom_range(0, 3) == 0);
			end
			if (long_hold && n == count / 3) begin
				hold_token <= hold_token + 1;
			end
			kind = $urandom_range(0, 7);
			upper = $urandom;
			lower = $urandom;
			upper_ovl = 24'($urandom);
			lower_ovl = 24'($urandom);
			case (kind)
				0: begin
					upper = 32'h11111111 * $urandom_range(0, 15);
					lower = 32'h11111111 * $urandom_range(0, 15);
				end
				1: begin
					upper_ovl = upper_ovl & 24'o33333333;
					lower_ovl = lower_ovl & 24'o33333333;
				end
				2: begin
					upper_ovl = upper_ovl | 24'o44444444;
					lower_ovl = lower_ovl | 24'o44444444;
				end
				default: begin
				end
			endcase
			offer_group(upper, lower, upper_ovl, lower_ovl, $urandom_range(0, 5) == 0);
			burst_left--;
		end
	endtask

	initial begin
		int mode;
		int span;
		int seen;
		seen = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(posedge clk);
				if (hold_token != seen) begin
					seen = hold_token;
					m_axis_tready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Overlay off: the overlay fields must have no effect, and all pages are visited.
		write_overlay_enable(1'b0);
		offer_group(32'h00000000, 32'h00000000, 24'h000000, 24'h000000, 1'b0);
		offer_group(32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
		for (int p = 0; p < gfbp_pkg::PAGE_COUNT; p++) begin
			offer_group(32'h76543210, 32'hFEDCBA98, 24'h000000, 24'h000000, 1'b0);
			offer_group(32'hFEDCBA98, 32'h76543210, 24'o01234567, 24'h000000, 1'b1);
		end
		await_drain();

		// Overlay on: opaque colors, transparent pixels and a mix of both.
		write_overlay_enable(1'b1);
		offer_group(32'hFFFFFFFF, 32'h00000000, 24'h000000, 24'h000000, 1'b0);
		offer_group(32'h00000000, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
		offer_group(32'h76543210, 32'hFEDCBA98, 24'o76543210, 24'o01234567, 1'b1);
		offer_group(32'hFEDCBA98, 32'h76543210, 24'o33332222, 24'o11110000, 1'b1);
		offer_group(32'h00000000, 32'h00000000, 24'o33333333, 24'o33333333, 1'b0);

		stream_random_groups(RANDOM_ITEMS, 1'b0);
		await_drain();
		write_overlay_enable(1'b0);
		stream_random_groups(RANDOM_ITEMS, 1'b1);
		await_drain();
		write_overlay_enable(1'b1);
		stream_random_groups(RANDOM_ITEMS, 1'b0);
		await_drain();
		write_overlay_enable(1'b0);
		stream_random_groups(RANDOM_ITEMS, 1'b0);
		await_drain();
		repeat (8) @(posedge clk);

		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/gfbp_pkg.sv
sv/gfbp_lane.sv
sv/gfbp_merge.sv
sv/gray_frc_bitplane_packer.sv
bench/gfbp_lcd_checker.sv
bench/tb_gray_frc_bitplane_packer.sv
